>>> rtl/core/bsa_pkg.sv
// Shared types and constants of the bitmap slot allocator.
// Used by bsa_ctrl, bsa_datapath, bitmap_slot_allocator_top and the testbench; depends on nothing.
package bsa_pkg;

    // Request kinds
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_CHECK = 2'd2;

    // Controller states, one-hot
    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic clear_step;  // write one zero word of the clearing pass
        logic take;        // capture the request and read its word
        logic exec;        // modify and write back the word, load the result
    } t_ctrl_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic clear_last;  // clearing pass is at its last word
        logic out_free;    // result register can take a new result
    } t_dp_status;

endpackage

>>> rtl/core/bsa_ctrl.sv
// Controller of the bitmap slot allocator: clearing pass, accept, execute.
// Depends on bsa_pkg for the state type and the command and status structs.
module bsa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  bsa_pkg::t_dp_status i_status,
    output bsa_pkg::t_ctrl_cmd  o_cmd,
    output logic                o_stall
);

    bsa_pkg::t_state r_state;
    bsa_pkg::t_state n_state;

    // Decode commands and next state
    always_comb begin
        n_state          = r_state;
        o_cmd.clear_step = 1'b0;
        o_cmd.take       = 1'b0;
        o_cmd.exec       = 1'b0;
        case (r_state)
            bsa_pkg::ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_last) begin
                    n_state = bsa_pkg::ST_IDLE;
                end
            end
            bsa_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = bsa_pkg::ST_EXEC;
                end
            end
            bsa_pkg::ST_EXEC: begin
                // hold until the result register has room
                if (i_status.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = bsa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bsa_pkg::ST_CLEAR;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsa_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != bsa_pkg::ST_IDLE);

endmodule

>>> rtl/core/bsa_datapath.sv
// Datapath of the bitmap slot allocator: slot map memory, per-word full flags,
// request registers, word read-modify-write and the result register. Uses bsa_pkg.
module bsa_datapath #(
    parameter int TOTAL_SLOTS = 1024,
    parameter int WORD_WIDTH  = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bsa_pkg::t_ctrl_cmd  i_cmd,
    output bsa_pkg::t_dp_status o_status,
    input  logic [1:0]          i_op,
    input  logic [9:0]          i_slot_index,
    input  logic                i_stall,
    output logic                o_valid,
    output logic                o_success,
    output logic [9:0]          o_granted_index,
    output logic                o_in_use
);

    localparam int NUM_WORDS = (TOTAL_SLOTS + WORD_WIDTH - 1) / WORD_WIDTH;
    localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_WIDTH);
    localparam int LAST_BITS = TOTAL_SLOTS - (NUM_WORDS - 1) * WORD_WIDTH;
    localparam logic [WA_W-1:0] LAST_WORD = WA_W'(NUM_WORDS - 1);
    // reciprocal for the index split: exact floor for 10-bit indexes
    localparam int DIV_SH = 17;
    localparam int DIV_M  = ((1 << DIV_SH) + WORD_WIDTH - 1) / WORD_WIDTH;

    logic [WORD_WIDTH-1:0] r_mem [NUM_WORDS];
    logic [WORD_WIDTH-1:0] r_rd_data;
    logic [NUM_WORDS-1:0]  r_full;
    logic [WA_W-1:0]       r_clr_addr;

    logic [1:0]            r_op;
    logic                  r_idx_ok;
    logic                  r_found;
    logic [WA_W-1:0]       r_word;
    logic [BIT_W-1:0]      r_bit;
    logic [9:0]            r_base;

    logic                  r_out_valid;
    logic                  r_success;
    logic [9:0]            r_granted;
    logic                  r_in_use;

    // Split the request index into word and bit
    logic [26:0]      div_prod;
    logic [9:0]       idx_word10;
    logic [16:0]      word_start;
    logic [9:0]       idx_rem;
    logic [WA_W-1:0]  idx_word;
    logic [BIT_W-1:0] idx_bit;
    logic             idx_ok;

    assign div_prod   = 27'(i_slot_index) * 27'(DIV_M);
    assign idx_word10 = div_prod[DIV_SH+9:DIV_SH];
    assign word_start = 17'(idx_word10) * 17'(WORD_WIDTH);
    assign idx_rem    = i_slot_index - word_start[9:0];
    assign idx_word   = WA_W'(idx_word10);
    assign idx_bit    = idx_rem[BIT_W-1:0];
    assign idx_ok     = (32'(i_slot_index) < TOTAL_SLOTS);

    // Pick the lowest word that still has a free slot
    logic [WA_W-1:0] first_word;
    logic            any_free;
    logic [31:0]     base_prod;

    always_comb begin
        first_word = '0;
        any_free   = 1'b0;
        for (int i = NUM_WORDS - 1; i >= 0; i--) begin
            if (!r_full[i]) begin
                first_word = WA_W'(i);
                any_free   = 1'b1;
            end
        end
    end

    assign base_prod = 32'(first_word) * 32'(WORD_WIDTH);

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op     <= i_op;
            r_idx_ok <= idx_ok;
            r_found  <= any_free;
            r_word   <= (i_op == bsa_pkg::OP_ALLOC) ? first_word : idx_word;
            r_bit    <= idx_bit;
            r_base   <= base_prod[9:0];
        end
    end

    // Read the addressed word
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_rd_data <= r_mem[(i_op == bsa_pkg::OP_ALLOC) ? first_word : idx_word];
        end
    end

    // Valid-slot mask of the word in work; the last word may be partial
    logic [WORD_WIDTH-1:0] last_mask;
    logic [WORD_WIDTH-1:0] word_mask;

    always_comb begin
        for (int i = 0; i < WORD_WIDTH; i++) begin
            last_mask[i] = (i < LAST_BITS);
        end
    end

    assign word_mask = (r_word == LAST_WORD) ? last_mask : '1;

    // Lowest free bit of the word
    logic [WORD_WIDTH-1:0] free_bits;
    logic [BIT_W-1:0]      pick;

    assign free_bits = ~r_rd_data & word_mask;

    always_comb begin
        pick = '0;
        for (int i = WORD_WIDTH - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                pick = BIT_W'(i);
            end
        end
    end

    // Modify the word and form the result
    logic [WORD_WIDTH-1:0] new_word;
    logic                  do_write;
    logic                  res_success;
    logic [9:0]            res_granted;
    logic                  res_in_use;

    always_comb begin
        new_word    = r_rd_data;
        do_write    = 1'b0;
        res_success = 1'b0;
        res_granted = '0;
        res_in_use  = 1'b0;
        case (r_op)
            bsa_pkg::OP_ALLOC: begin
                if (r_found) begin
                    new_word    = r_rd_data | (WORD_WIDTH'(1) << pick);
                    do_write    = 1'b1;
                    res_success = 1'b1;
                    res_granted = r_base + 10'(pick);
                end
            end
            bsa_pkg::OP_FREE: begin
                res_success = 1'b1;
                if (r_idx_ok) begin
                    new_word = r_rd_data & ~(WORD_WIDTH'(1) << r_bit);
                    do_write = 1'b1;
                end
            end
            bsa_pkg::OP_CHECK: begin
                res_success = 1'b1;
                res_in_use  = r_idx_ok & r_rd_data[r_bit];
            end
            default: begin
                // unused code: no change, all-zero result
                do_write = 1'b0;
            end
        endcase
    end

    // Memory write port: clearing pass or write-back
    logic                  wr_en;
    logic [WA_W-1:0]       wr_addr;
    logic [WORD_WIDTH-1:0] wr_data;

    assign wr_en   = i_cmd.clear_step | (i_cmd.exec & do_write);
    assign wr_addr = i_cmd.clear_step ? r_clr_addr : r_word;
    assign wr_data = i_cmd.clear_step ? '0 : new_word;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    // Advance the clearing address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr_addr <= r_clr_addr + WA_W'(1);
        end
    end

    assign o_status.clear_last = (r_clr_addr == LAST_WORD);

    // Track which words have no free slot left
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= '0;
        end else if (i_cmd.exec && do_write) begin
            r_full[r_word] <= &(new_word | ~word_mask);
        end
    end

    // Result register: load on execute, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_success <= res_success;
            r_granted <= res_granted;
            r_in_use  <= res_in_use;
        end
    end

    assign o_status.out_free = !r_out_valid || !i_stall;

    assign o_valid         = r_out_valid;
    assign o_success       = r_success;
    assign o_granted_index = r_granted;
    assign o_in_use        = r_in_use;

endmodule

>>> rtl/core/bitmap_slot_allocator_top.sv
// Top level of the bitmap slot allocator: first-fit allocation over a slot map.
// Instantiates bsa_ctrl and bsa_datapath; uses bsa_pkg for the joining structs.
//
//   channel  direction  handshake           payload
//   request  in         i_valid / o_stall   i_op, i_slot_index
//   result   out        o_valid / i_stall   o_success, o_granted_index, o_in_use
//
// Each request is taken in the idle state, which picks the word (full-flag
// priority encode) and reads it, and is then executed with the read-modify-write
// of that word through the single memory write port. A result waiting in the
// output register does not block the next request from being taken; only its
// execute step waits for room. After reset a clearing pass writes zero to every
// map word, one a cycle; o_stall is high throughout.
module bitmap_slot_allocator_top #(
    parameter int TOTAL_SLOTS = 1024,
    parameter int WORD_WIDTH  = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_op,
    input  logic [9:0] i_slot_index,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_success,
    output logic [9:0] o_granted_index,
    output logic       o_in_use
);

    bsa_pkg::t_ctrl_cmd  cmd;
    bsa_pkg::t_dp_status status;

    bsa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_cmd    (cmd),
        .o_stall  (o_stall)
    );

    bsa_datapath #(
        .TOTAL_SLOTS (TOTAL_SLOTS),
        .WORD_WIDTH  (WORD_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_op            (i_op),
        .i_slot_index    (i_slot_index),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_success       (o_success),
        .o_granted_index (o_granted_index),
        .o_in_use        (o_in_use)
    );

endmodule

>>> sim/tb_bitmap_slot_allocator_top.sv
// Self-checking testbench for bitmap_slot_allocator_top: first-fit slot allocation.
// Depends on bsa_pkg for the request codes; keeps its own copy of the slot map to
// predict every result transfer.
module tb_bitmap_slot_allocator_top;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int NUM_WORDS     = 16;
    localparam int MAP_WORD_W    = 64;
    localparam int NUM_SLOTS     = NUM_WORDS * MAP_WORD_W;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic       success;
        logic [9:0] granted_index;
        logic       in_use;
    } t_slot_result;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_RUNS
    } t_stall_mode;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [1:0] i_op = bsa_pkg::OP_ALLOC;
    logic [9:0] i_slot_index = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic       o_success;
    logic [9:0] o_granted_index;
    logic       o_in_use;

    // Mirror of the slot map, one bit per slot, set when in use
    logic [MAP_WORD_W-1:0] slot_words [NUM_WORDS] = '{default: '0};
    t_slot_result          pending_results [$];
    int                    error_count = 0;
    int                    cycle_count = 0;
    int                    burst_left  = 0;
    int                    gap_left    = 0;

    bitmap_slot_allocator_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_slot_index    (i_slot_index),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_success       (o_success),
        .o_granted_index (o_granted_index),
        .o_in_use        (o_in_use)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one request to the mirror map and return the result it must produce
    function automatic t_slot_result apply_request(input logic [1:0] op,
                                                   input logic [9:0] idx);
        t_slot_result res;
        logic         found;
        res   = '0;
        found = 1'b0;
        case (op)
            bsa_pkg::OP_ALLOC: begin
                // lowest free slot wins; a full map leaves everything at zero
                for (int w = 0; w < NUM_WORDS; w++) begin
                    for (int b = 0; b < MAP_WORD_W; b++) begin
                        if (!found && !slot_words[w][b]) begin
                            found             = 1'b1;
                            slot_words[w][b]  = 1'b1;
                            res.success       = 1'b1;
                            res.granted_index = 10'(w * MAP_WORD_W + b);
                        end
                    end
                end
            end
            bsa_pkg::OP_FREE: begin
                slot_words[idx[9:6]][idx[5:0]] = 1'b0;
                res.success = 1'b1;
            end
            bsa_pkg::OP_CHECK: begin
                res.success = 1'b1;
                res.in_use  = slot_words[idx[9:6]][idx[5:0]];
            end
            default: begin
                // unused code: no change, all-zero result
            end
        endcase
        return res;
    endfunction

    // Pick a slot that is in use, starting from a random place; random if none is
    function automatic logic [9:0] pick_used_slot();
        logic [9:0] start;
        logic [9:0] probe;
        start = 10'($urandom_range(0, NUM_SLOTS - 1));
        for (int k = 0; k < NUM_SLOTS; k++) begin
            probe = start + 10'(k);
            if (slot_words[probe[9:6]][probe[5:0]])
                return probe;
        end
        return start;
    endfunction

    // Offer one request, hold it until the transfer, then record its expected result
    task automatic send_request(input logic [1:0] op, input logic [9:0] idx);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (gap_left > 0) begin
            i_valid <= 1'b0;
            repeat (gap_left) @(posedge i_clk);
            gap_left = 0;
        end
        i_valid      <= 1'b1;
        i_op         <= op;
        i_slot_index <= idx;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(apply_request(op, idx));
        burst_left--;
    endtask

    // Drop valid and hold off until every outstanding result has arrived
    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Extremes of the fields, every request kind, slot reuse and the unused code
    task automatic test_basic_requests();
        send_request(bsa_pkg::OP_ALLOC, 10'h000);
        send_request(bsa_pkg::OP_ALLOC, 10'h3FF);    // index is ignored on allocate
        send_request(bsa_pkg::OP_CHECK, 10'h000);
        send_request(bsa_pkg::OP_CHECK, 10'h3FF);
        send_request(bsa_pkg::OP_CHECK, 10'h001);
        send_request(bsa_pkg::OP_FREE, 10'h000);
        send_request(bsa_pkg::OP_CHECK, 10'h000);
        send_request(bsa_pkg::OP_ALLOC, 10'h155);    // takes slot 0 again
        send_request(bsa_pkg::OP_FREE, 10'h3FF);     // freeing a free slot
        send_request(bsa_pkg::OP_CHECK, 10'h3FF);
        send_request(OP_UNUSED, 10'h3FF);
        send_request(OP_UNUSED, 10'h000);
        send_request(bsa_pkg::OP_CHECK, 10'h2AA);
        send_request(bsa_pkg::OP_CHECK, 10'h155);
        send_request(bsa_pkg::OP_FREE, 10'h001);
        send_request(bsa_pkg::OP_CHECK, 10'h001);
        send_request(bsa_pkg::OP_ALLOC, 10'h2AA);
        send_request(bsa_pkg::OP_ALLOC, 10'h000);
        send_request(bsa_pkg::OP_CHECK, 10'h002);
        send_request(bsa_pkg::OP_FREE, 10'h155);
    endtask

    // Mixed traffic; frees and checks mostly aim at slots in use
    task automatic test_random_mix();
        int         kind;
        logic [9:0] idx;
        repeat (150) begin
            kind = $urandom_range(0, 99);
            idx  = ($urandom_range(0, 9) < 6) ? pick_used_slot() : 10'($urandom);
            if (kind < 40)
                send_request(bsa_pkg::OP_ALLOC, 10'($urandom));
            else if (kind < 70)
                send_request(bsa_pkg::OP_FREE, idx);
            else if (kind < 95)
                send_request(bsa_pkg::OP_CHECK, idx);
            else
                send_request(OP_UNUSED, 10'($urandom));
        end
    endtask

    // Fill the map, hit the map-full case, then free and reclaim slots
    task automatic test_fill_and_reclaim();
        int         allocs;
        logic [9:0] idx;
        allocs = 0;
        while (allocs < NUM_SLOTS) begin
            if ($urandom_range(0, 9) == 0) begin
                send_request(bsa_pkg::OP_CHECK, 10'($urandom));
            end else begin
                send_request(bsa_pkg::OP_ALLOC, 10'($urandom));
                allocs++;
            end
        end
        // map is full now: allocates must fail and change nothing
        repeat (4) send_request(bsa_pkg::OP_ALLOC, 10'($urandom));
        send_request(bsa_pkg::OP_CHECK, 10'h3FF);
        // free one slot and take it straight back
        repeat (40) begin
            idx = 10'($urandom);
            send_request(bsa_pkg::OP_FREE, idx);
            send_request(bsa_pkg::OP_ALLOC, 10'($urandom));
            send_request(bsa_pkg::OP_CHECK, idx);
        end
        // free a batch, then allocate past the point of running out again
        repeat (20) send_request(bsa_pkg::OP_FREE, pick_used_slot());
        repeat (25) send_request(bsa_pkg::OP_ALLOC, 10'($urandom));
        repeat (100) begin
            if ($urandom_range(0, 3) == 0)
                send_request(bsa_pkg::OP_CHECK, 10'($urandom));
            else
                send_request(bsa_pkg::OP_FREE, pick_used_slot());
        end
    endtask

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_slot_result exp_res;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no request outstanding");
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_success !== exp_res.success) begin
                    $error("success: expected %0d, got %0d", exp_res.success, o_success);
                    error_count++;
                end
                if (o_granted_index !== exp_res.granted_index) begin
                    $error("granted_index: expected %0d, got %0d",
                           exp_res.granted_index, o_granted_index);
                    error_count++;
                end
                if (o_in_use !== exp_res.in_use) begin
                    $error("in_use: expected %0d, got %0d", exp_res.in_use, o_in_use);
                    error_count++;
                end
            end
        end
    end

    // Receiver stall pattern: switch between no stall, random stall and long runs
    t_stall_mode stall_mode  = STALL_NONE;
    int          mode_left   = 0;
    int          run_left    = 0;
    logic        stall_level = 1'b0;

    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 2));
            mode_left  = $urandom_range(50, 300);
        end
        mode_left--;
        case (stall_mode)
            STALL_NONE: begin
                i_stall <= 1'b0;
            end
            STALL_RANDOM: begin
                i_stall <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                if (run_left == 0) begin
                    stall_level = ~stall_level;
                    run_left    = $urandom_range(1, 8);
                end
                run_left--;
                i_stall <= stall_level;
            end
        endcase
    end

    // Guard against a hung handshake
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_requests();
        wait_for_results();
        test_random_mix();
        wait_for_results();
        test_fill_and_reclaim();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/bsa_pkg.sv
rtl/core/bsa_ctrl.sv
rtl/core/bsa_datapath.sv
rtl/core/bitmap_slot_allocator_top.sv
sim/tb_bitmap_slot_allocator_top.sv
